>>> rtl/ccid_pkg.sv
package ccid_pkg;

    localparam int HDR_BYTES      = 10;
    localparam int PARAM_DEPTH    = 7;
    localparam int CNT_W          = 10;
    localparam int MAX_MSG_BYTES  = 512;
    localparam int QUEUE_DEPTH    = 2;

    // Request types
    localparam logic [7:0] MSG_SET_PARAMS   = 8'h61;
    localparam logic [7:0] MSG_POWER_ON     = 8'h62;
    localparam logic [7:0] MSG_GET_PARAMS   = 8'h6C;
    localparam logic [7:0] MSG_RESET_PARAMS = 8'h6D;
    localparam logic [7:0] MSG_XFR_BLOCK    = 8'h6F;

    // Response types
    localparam logic [7:0] RSP_DATA_BLOCK   = 8'h80;
    localparam logic [7:0] RSP_SLOT_STATUS  = 8'h81;
    localparam logic [7:0] RSP_PARAMS       = 8'h82;

    localparam logic [7:0] PROTO_T1         = 8'h01;

    localparam logic [PARAM_DEPTH-1:0][7:0] DEFAULT_T1 =
        {8'h00, 8'hFE, 8'h00, 8'h45, 8'h00, 8'h10, 8'h11};
    localparam logic [PARAM_DEPTH-1:0][7:0] XFR_PAYLOAD =
        {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h6F};

    // Everything the back end needs to stream one response
    typedef struct packed {
        logic [7:0]                   kind;
        logic [7:0]                   seq;
        logic [7:0]                   last_hdr;
        logic [2:0]                   pay_cnt;
        logic [PARAM_DEPTH-1:0][7:0]  payload;
    } t_resp_desc;

endpackage

>>> rtl/ccid_front.sv
module ccid_front #(
    parameter int MAX_MSG_BYTES = ccid_pkg::MAX_MSG_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_host_byte,
    input  logic                 i_q_full,
    output logic                 o_push,
    output ccid_pkg::t_resp_desc o_desc
);

    localparam logic [31:0] LenLimit = 32'(MAX_MSG_BYTES - ccid_pkg::HDR_BYTES);
    localparam logic [ccid_pkg::CNT_W-1:0] HdrCnt = ccid_pkg::CNT_W'(ccid_pkg::HDR_BYTES);
    localparam logic [ccid_pkg::CNT_W-1:0] PayEnd =
        ccid_pkg::CNT_W'(ccid_pkg::HDR_BYTES + ccid_pkg::PARAM_DEPTH);

    logic [ccid_pkg::CNT_W-1:0] r_byte_count, n_byte_count;
    logic [7:0]                 r_msg_type, n_msg_type;
    logic [31:0]                r_len, n_len;
    logic [7:0]                 r_seq, n_seq;
    logic [7:0]                 r_proto, n_proto;
    logic [ccid_pkg::PARAM_DEPTH-1:0][7:0] r_param, n_param;

    logic                       accept;
    logic [ccid_pkg::CNT_W-1:0] cnt;
    logic [ccid_pkg::CNT_W-1:0] pay_off;
    logic [ccid_pkg::CNT_W:0]   expected;
    logic                       hdr_done;
    logic                       drop;
    logic                       complete;
    logic [2:0]                 np;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign cnt     = r_byte_count + 1'b1;
    assign pay_off = r_byte_count - HdrCnt;

    always_comb begin
        n_msg_type = r_msg_type;
        n_len      = r_len;
        n_seq      = r_seq;
        n_proto    = r_proto;
        n_param    = r_param;
        case (r_byte_count)
            10'd0: n_msg_type = i_host_byte;
            10'd1: n_len[7:0]   = i_host_byte;
            10'd2: n_len[15:8]  = i_host_byte;
            10'd3: n_len[23:16] = i_host_byte;
            10'd4: n_len[31:24] = i_host_byte;
            10'd6: n_seq   = i_host_byte;
            10'd7: n_proto = i_host_byte;
            default: begin
                if (r_byte_count >= HdrCnt && r_byte_count < PayEnd) begin
                    n_param[pay_off[2:0]] = i_host_byte;
                end
            end
        endcase
    end

    // Length is whole once the header is in, so it is checked against the limit here
    assign hdr_done = cnt >= HdrCnt;
    assign drop     = hdr_done && (n_len > LenLimit);
    assign expected = (ccid_pkg::CNT_W+1)'(ccid_pkg::HDR_BYTES)
                    + {1'b0, n_len[ccid_pkg::CNT_W-1:0]};
    assign complete = hdr_done && !drop && ({1'b0, cnt} >= expected);

    always_comb begin
        if (drop || complete) begin
            n_byte_count = '0;
        end else begin
            n_byte_count = cnt;
        end
    end

    assign np = (n_len[7:3] != 5'd0) ? 3'(ccid_pkg::PARAM_DEPTH) : n_len[2:0];

    always_comb begin
        o_desc.seq      = n_seq;
        o_desc.kind     = ccid_pkg::RSP_SLOT_STATUS;
        o_desc.last_hdr = 8'h00;
        o_desc.pay_cnt  = 3'd0;
        o_desc.payload  = n_param;
        case (n_msg_type)
            ccid_pkg::MSG_POWER_ON: begin
                o_desc.kind = ccid_pkg::RSP_DATA_BLOCK;
            end
            ccid_pkg::MSG_XFR_BLOCK: begin
                o_desc.kind    = ccid_pkg::RSP_DATA_BLOCK;
                o_desc.pay_cnt = 3'd2;
                o_desc.payload = ccid_pkg::XFR_PAYLOAD;
            end
            ccid_pkg::MSG_SET_PARAMS: begin
                o_desc.kind     = ccid_pkg::RSP_PARAMS;
                o_desc.last_hdr = ccid_pkg::PROTO_T1;
                o_desc.pay_cnt  = 3'(ccid_pkg::PARAM_DEPTH);
                if (np != 3'd0) begin
                    o_desc.pay_cnt = np;
                    if (n_proto != 8'h00) begin
                        o_desc.last_hdr = n_proto;
                    end
                end else begin
                    o_desc.payload = ccid_pkg::DEFAULT_T1;
                end
            end
            ccid_pkg::MSG_GET_PARAMS, ccid_pkg::MSG_RESET_PARAMS: begin
                o_desc.kind     = ccid_pkg::RSP_PARAMS;
                o_desc.last_hdr = ccid_pkg::PROTO_T1;
                o_desc.pay_cnt  = 3'(ccid_pkg::PARAM_DEPTH);
                o_desc.payload  = ccid_pkg::DEFAULT_T1;
            end
            default: begin
                o_desc.kind = ccid_pkg::RSP_SLOT_STATUS;
            end
        endcase
    end

    assign o_push = accept && complete;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_msg_type   <= '0;
            r_len        <= '0;
            r_seq        <= '0;
            r_proto      <= '0;
        end else if (accept) begin
            r_byte_count <= n_byte_count;
            r_msg_type   <= n_msg_type;
            r_len        <= n_len;
            r_seq        <= n_seq;
            r_proto      <= n_proto;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_param <= n_param;
        end
    end

endmodule

>>> rtl/ccid_queue.sv
module ccid_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ccid_pkg::t_resp_desc i_desc,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output ccid_pkg::t_resp_desc o_desc
);

    localparam int PtrW = (ccid_pkg::QUEUE_DEPTH > 1) ? $clog2(ccid_pkg::QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(ccid_pkg::QUEUE_DEPTH + 1);
    localparam logic [CntW-1:0] Depth = CntW'(ccid_pkg::QUEUE_DEPTH);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(ccid_pkg::QUEUE_DEPTH - 1);

    ccid_pkg::t_resp_desc r_mem [ccid_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;

    assign o_full  = (r_count == Depth);
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("response queue written while full");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("response queue read while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= Depth) && ((r_count == '0) == (r_wr_ptr == r_rd_ptr) || o_full))
        else $error("response queue count out of step with pointers");
`endif

endmodule

>>> rtl/ccid_back.sv
module ccid_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  ccid_pkg::t_resp_desc i_desc,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_resp_byte,
    output logic                 o_resp_last
);

    logic [4:0] r_k;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    logic       load;
    logic       is_last;
    logic [4:0] last_idx;
    logic [4:0] pay_off;
    logic [7:0] cur_byte;

    assign load     = i_q_valid && (!r_valid || i_ready);
    assign last_idx = 5'(ccid_pkg::HDR_BYTES - 1) + {2'b00, i_desc.pay_cnt};
    assign is_last  = (r_k == last_idx);
    assign pay_off  = r_k - 5'(ccid_pkg::HDR_BYTES);

    always_comb begin
        case (r_k)
            5'd0:    cur_byte = i_desc.kind;
            5'd1:    cur_byte = {5'b00000, i_desc.pay_cnt};
            5'd6:    cur_byte = i_desc.seq;
            5'd9:    cur_byte = i_desc.last_hdr;
            default: begin
                if (r_k >= 5'(ccid_pkg::HDR_BYTES)) begin
                    cur_byte = i_desc.payload[pay_off[2:0]];
                end else begin
                    cur_byte = 8'h00;
                end
            end
        endcase
    end

    // Release the queue entry as its final byte moves to the output register
    assign o_pop = load && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_k     <= is_last ? 5'd0 : r_k + 1'b1;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= cur_byte;
            r_last <= is_last;
        end
    end

    assign o_valid     = r_valid;
    assign o_resp_byte = r_byte;
    assign o_resp_last = r_last;

`ifndef ASSERT_OFF
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> (r_k <= last_idx))
        else $error("byte index past end of response");
    a_k_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && is_last) |=> (r_k == 5'd0))
        else $error("byte index not cleared after final byte");
    a_k_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !is_last) |=> (r_k == $past(r_k) + 5'd1) && !o_resp_last)
        else $error("byte index skipped or early final byte");
`endif

endmodule

>>> rtl/ccid_message_deframer_responder.sv
// CCID bulk message deframer and responder.
// Input channel: one host-to-reader byte per request on i_host_byte, handshake
// i_valid / o_ready. Output channel: one response byte per request on
// o_resp_byte with o_resp_last on the final byte, handshake o_valid / i_ready.
// The front end parses the 10-byte header and up to 7 payload bytes and, on
// the last byte of a message, writes a response descriptor into a two-entry
// queue. The back end streams each descriptor out as 10 to 17 bytes.
// Input takes one byte per cycle while the queue has room. Output gives one
// byte per cycle while i_ready is high; the first response byte passes the
// queue and the output register after the message's final byte is accepted.
// Short messages are limited by the output side: a response holds the back
// end until its last byte is out, and o_ready drops while two responses wait.
// Oversized messages are dropped without a response and parsing restarts on
// the next byte.
// Reset clears the byte counter, header fields, queue and output register.
// A stalled receiver holds the current output byte; the queue then fills and
// the input side stalls in turn.
module ccid_message_deframer_responder #(
    parameter int MAX_MSG_BYTES = ccid_pkg::MAX_MSG_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_host_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_resp_byte,
    output logic       o_resp_last
);

    ccid_pkg::t_resp_desc push_desc;
    ccid_pkg::t_resp_desc head_desc;
    logic                 push;
    logic                 q_full;
    logic                 q_valid;
    logic                 pop;

    ccid_front #(
        .MAX_MSG_BYTES(MAX_MSG_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_host_byte (i_host_byte),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_desc      (push_desc)
    );

    ccid_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_desc  (head_desc)
    );

    ccid_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_desc      (head_desc),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_resp_byte (o_resp_byte),
        .o_resp_last (o_resp_last)
    );

endmodule

>>> dv/tb_ccid_message_deframer_responder.sv
`timescale 1ns / 1ps

module tb_ccid_message_deframer_responder;

    localparam logic [7:0] MSG_POWER_OFF   = 8'h63;
    localparam logic [7:0] MSG_SLOT_STATUS = 8'h65;
    localparam logic [7:0] MSG_UNKNOWN_HI  = 8'hFF;
    localparam logic [7:0] NO_LAST         = 8'h00;

    localparam int RAND_BYTES  = 45;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 40;
    localparam int MAX_REPORTS = 10;

    typedef logic [ccid_pkg::PARAM_DEPTH-1:0][7:0] t_param_bytes;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_resp_beat;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_REPLY,
        CHK_SILENT
    } t_check_mode;

    typedef struct {
        logic [7:0]   mtype;
        logic [31:0]  len;
        logic [7:0]   seq;
        logic [7:0]   proto;
        logic [7:0]   fill;
        t_check_mode  check;
        logic [7:0]   rsp_kind;
        int unsigned  rsp_n;
        logic [7:0]   rsp_last;
        t_param_bytes rsp_pay;
    } t_msg_row;

    // Directed messages. Rows marked CHK_REPLY carry the answer typed in and
    // CHK_SILENT rows expect none; CHK_MODEL rows are left to the predictor.
    t_msg_row directed_msgs [14] = '{
        '{ccid_pkg::MSG_POWER_ON, 32'd0, 8'h00, 8'h00, 8'h00,
          CHK_REPLY, ccid_pkg::RSP_DATA_BLOCK, 0, NO_LAST, '0},
        '{ccid_pkg::MSG_XFR_BLOCK, 32'd2, 8'hFF, 8'hFF, 8'hFF,
          CHK_REPLY, ccid_pkg::RSP_DATA_BLOCK, 2, NO_LAST, ccid_pkg::XFR_PAYLOAD},
        '{ccid_pkg::MSG_SET_PARAMS, 32'd5, 8'h01, 8'h00, 8'h00,
          CHK_MODEL, 8'h00, 0, NO_LAST, '0},
        '{ccid_pkg::MSG_SET_PARAMS, 32'd7, 8'h80, 8'hFF, 8'hFF,
          CHK_MODEL, 8'h00, 0, NO_LAST, '0},
        '{ccid_pkg::MSG_SET_PARAMS, 32'd8, 8'h7F, 8'h02, 8'h5A,
          CHK_MODEL, 8'h00, 0, NO_LAST, '0},
        '{ccid_pkg::MSG_SET_PARAMS, 32'd0, 8'h22, 8'h03, 8'hA5,
          CHK_REPLY, ccid_pkg::RSP_PARAMS, ccid_pkg::PARAM_DEPTH,
          ccid_pkg::PROTO_T1, ccid_pkg::DEFAULT_T1},
        '{ccid_pkg::MSG_GET_PARAMS, 32'd0, 8'h33, 8'h00, 8'h00,
          CHK_REPLY, ccid_pkg::RSP_PARAMS, ccid_pkg::PARAM_DEPTH,
          ccid_pkg::PROTO_T1, ccid_pkg::DEFAULT_T1},
        '{ccid_pkg::MSG_RESET_PARAMS, 32'd3, 8'h44, 8'hC3, 8'h3C,
          CHK_REPLY, ccid_pkg::RSP_PARAMS, ccid_pkg::PARAM_DEPTH,
          ccid_pkg::PROTO_T1, ccid_pkg::DEFAULT_T1},
        '{MSG_POWER_OFF, 32'd0, 8'h55, 8'h00, 8'h00,
          CHK_REPLY, ccid_pkg::RSP_SLOT_STATUS, 0, NO_LAST, '0},
        '{MSG_UNKNOWN_HI, 32'd4, 8'h88, 8'hFF, 8'hFF,
          CHK_REPLY, ccid_pkg::RSP_SLOT_STATUS, 0, NO_LAST, '0},
        '{ccid_pkg::MSG_XFR_BLOCK, 32'd503, 8'h99, 8'h00, 8'h00,
          CHK_SILENT, 8'h00, 0, NO_LAST, '0},
        '{ccid_pkg::MSG_POWER_ON, 32'hFFFF_FFFF, 8'hAA, 8'hFF, 8'hFF,
          CHK_SILENT, 8'h00, 0, NO_LAST, '0},
        '{ccid_pkg::MSG_GET_PARAMS, 32'h0100_0000, 8'hBB, 8'h00, 8'h00,
          CHK_SILENT, 8'h00, 0, NO_LAST, '0},
        '{ccid_pkg::MSG_SET_PARAMS, 32'd1, 8'hEE, 8'h00, 8'hFF,
          CHK_MODEL, 8'h00, 0, NO_LAST, '0}
    };

    logic [7:0] known_types [7] = '{
        ccid_pkg::MSG_SET_PARAMS, ccid_pkg::MSG_POWER_ON, ccid_pkg::MSG_GET_PARAMS,
        ccid_pkg::MSG_RESET_PARAMS, ccid_pkg::MSG_XFR_BLOCK, MSG_POWER_OFF,
        MSG_SLOT_STATUS
    };

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_host_byte = 8'h00;
    logic       i_ready     = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_resp_byte;
    logic       o_resp_last;

    // Deframer state as the host stream has built it
    logic [9:0]   rx_count  = '0;
    logic [7:0]   rx_type   = '0;
    logic [31:0]  rx_len    = '0;
    logic [7:0]   rx_seq    = '0;
    logic [7:0]   rx_proto  = '0;
    t_param_bytes rx_params = '0;

    t_resp_beat pending_resp [$];
    logic       typed_now = 1'b0;
    logic       calm      = 1'b0;

    int unsigned mismatches  = 0;
    int unsigned idle_cycles = 0;
    int unsigned bytes_sent  = 0;
    int unsigned msgs_sent   = 0;
    int unsigned msgs_drop   = 0;
    int unsigned resp_seen   = 0;

    ccid_message_deframer_responder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_host_byte (i_host_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_resp_byte (o_resp_byte),
        .o_resp_last (o_resp_last)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic void emit_response(input logic [7:0] kind, input int unsigned n,
                                          input logic [7:0] seq, input logic [7:0] last,
                                          input t_param_bytes pay);
        logic [7:0]  frame [17];
        int unsigned total;
        total = ccid_pkg::HDR_BYTES + n;
        foreach (frame[k]) frame[k] = 8'h00;
        frame[0] = kind;
        frame[1] = n[7:0];
        frame[6] = seq;
        frame[9] = last;
        for (int unsigned k = 0; k < n; k++) frame[ccid_pkg::HDR_BYTES + k] = pay[k];
        for (int unsigned k = 0; k < total; k++) begin
            pending_resp.push_back('{frame[k], k == total - 1});
        end
    endfunction

    // Advance the deframer by one host byte and queue whatever response it completes
    function automatic void deframe_byte(input logic [7:0] b);
        logic [9:0]  idx;
        logic [32:0] total;
        int unsigned np;
        idx = rx_count;
        if (idx == 0) begin
            rx_type = b;
        end else if (idx <= 4) begin
            rx_len[8 * (idx - 1) +: 8] = b;
        end else if (idx == 6) begin
            rx_seq = b;
        end else if (idx == 7) begin
            rx_proto = b;
        end else if (idx >= ccid_pkg::HDR_BYTES &&
                     idx < ccid_pkg::HDR_BYTES + ccid_pkg::PARAM_DEPTH) begin
            rx_params[idx - ccid_pkg::HDR_BYTES] = b;
        end

        if (idx + 1 < ccid_pkg::HDR_BYTES) begin
            rx_count = idx + 10'd1;
            return;
        end
        total = {1'b0, rx_len} + ccid_pkg::HDR_BYTES;
        if (total > ccid_pkg::MAX_MSG_BYTES) begin
            rx_count = '0;
            msgs_drop++;
            return;
        end
        if (idx + 1 < total) begin
            rx_count = idx + 10'd1;
            return;
        end
        rx_count = '0;
        if (typed_now) return;

        case (rx_type)
            ccid_pkg::MSG_POWER_ON: begin
                emit_response(ccid_pkg::RSP_DATA_BLOCK, 0, rx_seq, NO_LAST, '0);
            end
            ccid_pkg::MSG_XFR_BLOCK: begin
                emit_response(ccid_pkg::RSP_DATA_BLOCK, 2, rx_seq, NO_LAST,
                              ccid_pkg::XFR_PAYLOAD);
            end
            ccid_pkg::MSG_SET_PARAMS: begin
                np = (rx_len[7:0] > ccid_pkg::PARAM_DEPTH) ? ccid_pkg::PARAM_DEPTH
                                                           : rx_len[7:0];
                if (np != 0) begin
                    emit_response(ccid_pkg::RSP_PARAMS, np, rx_seq,
                                  (rx_proto != 8'h00) ? rx_proto : ccid_pkg::PROTO_T1,
                                  rx_params);
                end else begin
                    emit_response(ccid_pkg::RSP_PARAMS, ccid_pkg::PARAM_DEPTH, rx_seq,
                                  ccid_pkg::PROTO_T1, ccid_pkg::DEFAULT_T1);
                end
            end
            ccid_pkg::MSG_GET_PARAMS, ccid_pkg::MSG_RESET_PARAMS: begin
                emit_response(ccid_pkg::RSP_PARAMS, ccid_pkg::PARAM_DEPTH, rx_seq,
                              ccid_pkg::PROTO_T1, ccid_pkg::DEFAULT_T1);
            end
            default: begin
                emit_response(ccid_pkg::RSP_SLOT_STATUS, 0, rx_seq, NO_LAST, '0);
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(0, 99) < 18) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_host_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        deframe_byte(b);
        bytes_sent++;
    endtask

    // Header first; the payload follows only if the message fits
    task automatic send_msg(input logic [7:0] mtype, input logic [31:0] len,
                            input logic [7:0] seq, input logic [7:0] proto,
                            input logic [7:0] fill);
        logic [32:0] total;
        total = {1'b0, len} + ccid_pkg::HDR_BYTES;
        send_byte(mtype);
        for (int k = 0; k < 4; k++) send_byte(len[8 * k +: 8]);
        send_byte(fill);
        send_byte(seq);
        send_byte(proto);
        send_byte(fill);
        send_byte(~fill);
        if (total <= ccid_pkg::MAX_MSG_BYTES) begin
            for (int unsigned k = 0; k < len; k++) send_byte(8'($urandom));
        end
        msgs_sent++;
    endtask

    function automatic void check_field(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("response byte %0d: %s expected %h, got %h",
                         resp_seen, what, want, got);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        i_ready <= !i_rst_n || calm || ($urandom_range(0, 99) >= 18);
    end

    always @(posedge i_clk) begin
        t_resp_beat want;
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (o_valid && i_ready) begin
                if (pending_resp.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("response byte %0d: unexpected %h last %b",
                                 resp_seen, o_resp_byte, o_resp_last);
                    end
                end else begin
                    want = pending_resp.pop_front();
                    check_field("data", want.data, o_resp_byte);
                    check_field("last", {7'd0, want.last}, {7'd0, o_resp_last});
                end
                resp_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("stalled with %0d response bytes outstanding", pending_resp.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        t_msg_row    row;
        int unsigned pick;
        int unsigned rand_start;
        logic [7:0]  mtype;
        logic [31:0] mlen;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_msgs[r]) begin
            row = directed_msgs[r];
            // Keep both sides busy through the middle of the table
            calm <= (r >= 2 && r < 9);
            typed_now = (row.check != CHK_MODEL);
            if (row.check == CHK_REPLY) begin
                emit_response(row.rsp_kind, row.rsp_n, row.seq, row.rsp_last, row.rsp_pay);
            end
            send_msg(row.mtype, row.len, row.seq, row.proto, row.fill);
        end
        typed_now = 1'b0;
        calm <= 1'b0;

        // Hold the host side until every queued response has drained
        i_valid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge i_clk);
        @(posedge i_clk);

        rand_start = bytes_sent;
        while (bytes_sent - rand_start < RAND_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                // broken header: length always too large, so the message is dropped
                mtype = 8'($urandom);
                mlen  = {8'($urandom_range(1, 255)), 24'($urandom)};
            end else begin
                pick  = $urandom_range(0, 8);
                mtype = (pick < 7) ? known_types[pick] : 8'($urandom);
                mlen  = $urandom_range(0, 9);
            end
            send_msg(mtype, mlen, 8'($urandom), 8'($urandom), 8'($urandom));
        end
        i_valid <= 1'b0;

        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d messages sent (%0d dropped as oversized), %0d host bytes",
                 msgs_sent, msgs_drop, bytes_sent);
        $display("%0d response bytes checked, %0d mismatches", resp_seen, mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
